// ----- design/adapter_tail_overlap_detect_unit_assert.svh -----
// Assertion macros shared by the adapter tail overlap detector.
`ifndef ADAPTER_TAIL_OVERLAP_DETECT_UNIT_ASSERT_SVH
`define ADAPTER_TAIL_OVERLAP_DETECT_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ATOD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ATOD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/atod_pkg.sv -----
// Package with the window size, adapter table and shared types of the detector.
`default_nettype none

package atod_pkg;

    // Number of bases held in the tail window.
    localparam int WIN_LEN = 19;

    // Number of adapters tried, in priority order.
    localparam int NUM_ADAPTERS = 2;

    // Adapter bytes, first prefix character last. The leftmost group is adapter 1.
    localparam logic [NUM_ADAPTERS-1:0][WIN_LEN-1:0][7:0] ADAPTER_TABLE = '{
        '{"G", "A", "C", "A", "G", "A", "G", "A", "A", "T",
          "A", "T", "G", "T", "G", "T", "A", "G", "A"},
        '{"T", "C", "T", "A", "C", "A", "C", "A", "T", "A",
          "T", "T", "C", "T", "C", "T", "G", "T", "C"}
    };

    // Reset value of the minimum overlap register.
    localparam logic [4:0] MIN_OVERLAP_RESET = 5'd8;

    // Qualified overlap hits of one read; bit L-1 stands for an overlap of L bases.
    typedef struct packed {
        logic [WIN_LEN-1:0] hit1;
        logic [WIN_LEN-1:0] hit0;
    } t_hit_set;

endpackage

`default_nettype wire

// ----- design/atod_front.sv -----
// Front end: tail window, base counter and parallel adapter comparators.
`default_nettype none

module atod_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [4:0]        i_min_overlap,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_base,
    input  wire logic              i_last,
    output atod_pkg::t_hit_set     o_hits
);
    import atod_pkg::*;

    logic [WIN_LEN-1:0][7:0] r_win;
    logic [WIN_LEN-1:0][7:0] n_win;
    logic [4:0]              r_seen;
    logic [4:0]              n_seen;
    logic [4:0]              seen_now;
    logic [4:0]              lo;
    t_hit_set                hits;

    // Window as it stands once the current base has shifted in, newest first.
    always_comb begin
        n_win[0] = i_base;
        for (int k = 1; k < WIN_LEN; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    // Base count including the current one, saturating at the window size.
    assign seen_now = (r_seen < 5'(WIN_LEN)) ? r_seen + 5'd1 : 5'(WIN_LEN);
    assign lo       = (i_min_overlap == 5'd0) ? 5'd1 : i_min_overlap;

    // A read end clears the count; otherwise it tracks the saturating count.
    assign n_seen = i_last ? 5'd0 : seen_now;

    // Compare every overlap length against both adapters at once.
    always_comb begin
        logic eq0;
        logic eq1;
        logic ok;
        hits = '0;
        for (int len = 1; len <= WIN_LEN; len++) begin
            eq0 = 1'b1;
            eq1 = 1'b1;
            for (int i = 0; i < WIN_LEN; i++) begin
                if (i < len) begin
                    if (n_win[len-1-i] != ADAPTER_TABLE[0][i]) begin
                        eq0 = 1'b0;
                    end
                    if (n_win[len-1-i] != ADAPTER_TABLE[1][i]) begin
                        eq1 = 1'b0;
                    end
                end
            end
            ok = (5'(len) <= seen_now) && (5'(len) >= lo);
            hits.hit0[len-1] = eq0 && ok;
            hits.hit1[len-1] = eq1 && ok;
        end
    end

    assign o_hits = hits;

    // The window holds payload only and needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

    // Base counter of the current read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 5'd0;
        end else if (i_accept) begin
            r_seen <= n_seen;
        end
    end

endmodule

`default_nettype wire

// ----- design/atod_queue.sv -----
// Short queue of hit sets between the front end and the back end.
`default_nettype none

module atod_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire atod_pkg::t_hit_set i_entry,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output atod_pkg::t_hit_set     o_entry
);
    import atod_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_hit_set           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push_ok;
    logic               pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/atod_back.sv -----
// Back end: picks the winning overlap and holds the result word.
`default_nettype none

module atod_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire atod_pkg::t_hit_set i_q_entry,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [4:0]             o_len,
    output logic                   o_sel
);
    import atod_pkg::*;

    logic       r_valid;
    logic [4:0] r_len;
    logic       r_sel;
    logic [4:0] len0;
    logic [4:0] len1;
    logic [4:0] n_len;
    logic       n_sel;
    logic       load;

    // Longest hit per adapter; higher lengths override lower ones.
    always_comb begin
        len0 = 5'd0;
        len1 = 5'd0;
        for (int len = 1; len <= WIN_LEN; len++) begin
            if (i_q_entry.hit0[len-1]) begin
                len0 = 5'(len);
            end
            if (i_q_entry.hit1[len-1]) begin
                len1 = 5'(len);
            end
        end
    end

    // Adapter 0 wins whenever it has any hit.
    always_comb begin
        if (len0 != 5'd0) begin
            n_len = len0;
            n_sel = 1'b0;
        end else if (len1 != 5'd0) begin
            n_len = len1;
            n_sel = 1'b1;
        end else begin
            n_len = 5'd0;
            n_sel = 1'b0;
        end
    end

    // Take a new entry when the output register is empty or being drained.
    assign load    = i_q_valid && (!r_valid || i_ready);
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_len <= n_len;
            r_sel <= n_sel;
        end
    end

    assign o_valid = r_valid;
    assign o_len   = r_len;
    assign o_sel   = r_sel;

endmodule

`default_nettype wire

// ----- design/adapter_tail_overlap_detect_unit.sv -----
// Top level of the adapter tail overlap detector.
// Read bases enter on the s_axis channel, one ASCII byte per word, with
// s_axis_tlast on the final base of a read. Each read gives one result word
// on the m_axis channel: the overlap length of the read tail with an adapter
// prefix in m_axis_tdata and the adapter number in m_axis_tuser.
// A base is taken every cycle while s_axis_tready is high. The front end
// compares the 19-base tail window against both adapters in parallel as the
// last base arrives; its hit set is queued at that edge and moves into the
// output register when that register is empty or being drained. Results
// leave at up to one per cycle.
// A queue of QUEUE_DEPTH hit sets plus the output register holds results
// while the receiver stalls; s_axis_tready falls only when the queue is full,
// and then input waits until a result is taken.
// The user writes the minimum overlap through i_cfg_we / i_cfg_wdata only
// while the block is idle (not enforced); a value of zero acts as one.
// Synchronous reset empties the queue and the output, clears the base count
// and sets the minimum overlap to 8. The window contents need no reset.
`default_nettype none

module adapter_tail_overlap_detect_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] base_char
    input  wire logic        s_axis_tlast,   // last_base
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [4:0] overlap_len, [7:5] zero
    output logic [0:0]       m_axis_tuser    // [0] adapter_sel
);
    import atod_pkg::*;

    `include "adapter_tail_overlap_detect_unit_assert.svh"

    logic [4:0] r_min_overlap;
    logic       in_accept;
    logic       q_push;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    t_hit_set   front_hits;
    t_hit_set   q_entry;
    logic [4:0] out_len;
    logic       out_sel;

    // Minimum overlap register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_overlap <= MIN_OVERLAP_RESET;
        end else if (i_cfg_we) begin
            r_min_overlap <= i_cfg_wdata;
        end
    end

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign q_push        = in_accept && s_axis_tlast;

    atod_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_min_overlap (r_min_overlap),
        .i_accept      (in_accept),
        .i_base        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .o_hits        (front_hits)
    );

    atod_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_hits),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_entry (q_entry)
    );

    atod_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_len     (out_len),
        .o_sel     (out_sel)
    );

    assign m_axis_tdata = {3'b000, out_len};
    assign m_axis_tuser = out_sel;

    // A queued result moves to an empty output register at the next edge.
    `ATOD_ASSERT_NEXT(a_back_pulls, q_valid && !m_axis_tvalid, m_axis_tvalid,
        "queued result not moved to the output")

    // No push is taken while the queue is full.
    `ATOD_ASSERT_NOW(a_no_push_full, q_push, !q_full, "push into a full queue")

    // A reported overlap is never shorter than the configured minimum.
    `ATOD_ASSERT_NOW(a_len_min, m_axis_tvalid && (out_len != 5'd0),
        (out_len >= r_min_overlap) && (out_len <= 5'(WIN_LEN)),
        "overlap length outside the configured range")

    // A zero overlap always reports adapter zero.
    `ATOD_ASSERT_NOW(a_zero_sel, m_axis_tvalid && (out_len == 5'd0), !out_sel,
        "adapter set without a match")

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the adapter tail overlap detector: reads in, one overlap word out.
`timescale 1ns / 1ps

import atod_pkg::*;

// Expected result word for one read.
typedef struct packed {
    logic [4:0] overlap_len;
    logic       adapter_sel;
} t_overlap_word;

// Receiver and sender behavior of one phase.
typedef enum logic [1:0] {
    FLOW_OPEN,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
} t_flow_mode;

// Tracks the tail window of the current read and checks each overlap word.
class overlap_scoreboard;
    byte unsigned  tail_bases[WIN_LEN];
    int unsigned   bases_in_read;
    logic [4:0]    min_overlap;
    string         adapter_text[NUM_ADAPTERS];
    t_overlap_word expected_words[$];
    int unsigned   mismatches;
    int unsigned   bases_taken;
    int unsigned   reads_done;
    int unsigned   reads_matched;
    int unsigned   full_window_hits;

    function new();
        adapter_text[0] = "CTGTCTCTTATACACATCT";
        adapter_text[1] = "AGATGTGTATAAGAGACAG";
        bases_in_read = 0;
        min_overlap = MIN_OVERLAP_RESET;
        mismatches = 0;
        bases_taken = 0;
        reads_done = 0;
        reads_matched = 0;
        full_window_hits = 0;
        foreach (tail_bases[i]) tail_bases[i] = 8'h00;
    endfunction

    function void set_min_overlap(logic [4:0] value);
        min_overlap = value;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    task report_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $realtime, msg);
        mismatches++;
    endtask

    // True when the newest len bases equal the first len bytes of the adapter.
    function bit tail_equals(int sel, int len);
        for (int i = 0; i < len; i++) begin
            if (tail_bases[len - 1 - i] != adapter_text[sel][i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Takes one accepted word; the last base of a read queues its overlap word.
    function void note_base(byte unsigned base_char, bit is_last);
        int            lo;
        t_overlap_word word;

        for (int i = WIN_LEN - 1; i > 0; i--)
            tail_bases[i] = tail_bases[i - 1];
        tail_bases[0] = base_char;
        if (bases_in_read < WIN_LEN)
            bases_in_read++;
        bases_taken++;
        if (!is_last)
            return;

        // A minimum of zero acts as one; the longest overlap of adapter 0 wins first.
        lo = (min_overlap == 0) ? 1 : int'(min_overlap);
        word = '0;
        if (int'(bases_in_read) >= lo) begin
            for (int sel = 0; sel < NUM_ADAPTERS && word.overlap_len == 0; sel++) begin
                for (int len = bases_in_read; len >= lo; len--) begin
                    if (tail_equals(sel, len)) begin
                        word.overlap_len = len[4:0];
                        word.adapter_sel = sel[0];
                        break;
                    end
                end
            end
        end
        expected_words.insert(expected_words.size(), word);
        reads_done++;
        if (word.overlap_len != 0)
            reads_matched++;
        if (word.overlap_len == WIN_LEN)
            full_window_hits++;
        bases_in_read = 0;
    endfunction

    // Compares one accepted result word with the oldest expectation.
    task check_result(logic [7:0] data, logic sel);
        t_overlap_word want;

        if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word data=%h sel=%b", data, sel));
            return;
        end
        want = expected_words.pop_front();
        if (data !== {3'b000, want.overlap_len})
            report_mismatch($sformatf("overlap length %h, expected %0d", data,
                want.overlap_len));
        if (sel !== want.adapter_sel)
            report_mismatch($sformatf("adapter %b, expected %0d", sel, want.adapter_sel));
    endtask
endclass

module testbench;

    localparam int NUM_PHASES = 9;
    localparam int BASES_PER_PHASE = 110;
    localparam logic [4:0] MIN_PLAN[NUM_PHASES] = '{
        5'd8, 5'd1, 5'd19, 5'd0, 5'd20, 5'd31, 5'd5, 5'd13, 5'd2
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [4:0] i_cfg_wdata = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    overlap_scoreboard sb = new();
    t_flow_mode        flow = FLOW_OPEN;
    byte unsigned      read_bases[$];

    adapter_tail_overlap_detect_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] base_char
        .s_axis_tlast  (s_axis_tlast),   // last_base
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [4:0] overlap_len, [7:5] zero
        .m_axis_tuser  (m_axis_tuser)    // [0] adapter_sel
    );

    always #2 i_clk = ~i_clk;

    function automatic bit roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // Result side: check each accepted word and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        case (flow)
            FLOW_RECV_STALLS: m_axis_tready <= !roll(84);
            FLOW_BOTH:        m_axis_tready <= !roll(8);
            default:          m_axis_tready <= 1'b1;
        endcase
    end

    // Mostly real bases, now and then any byte value.
    function automatic byte unsigned random_base();
        string acgt;

        acgt = "ACGT";
        if (roll(10))
            return 8'($urandom_range(0, 255));
        return acgt[$urandom_range(0, 3)];
    endfunction

    // Builds a read: random lead-in, usually ending in an adapter prefix, sometimes damaged.
    task automatic make_read();
        int kind;
        int lead;
        int k;
        int sel;
        int idx;

        read_bases.delete();
        kind = $urandom_range(0, 9);
        lead = roll(25) ? $urandom_range(0, 30) : $urandom_range(0, 8);
        for (int i = 0; i < lead; i++)
            read_bases.insert(read_bases.size(), random_base());
        if (kind < 7) begin
            sel = $urandom_range(0, NUM_ADAPTERS - 1);
            k = $urandom_range(1, WIN_LEN);
            for (int i = 0; i < k; i++)
                read_bases.insert(read_bases.size(), sb.adapter_text[sel][i]);
            if (kind == 6) begin
                idx = read_bases.size() - 1 - $urandom_range(0, k - 1);
                read_bases[idx] = read_bases[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        if (read_bases.size() == 0)
            read_bases.insert(0, random_base());
    endtask

    task automatic load_text(string text);
        read_bases.delete();
        for (int i = 0; i < text.len(); i++)
            read_bases.insert(read_bases.size(), text[i]);
    endtask

    // Sends one word and waits for it to be taken.
    task automatic send_base(byte unsigned base_char, bit is_last);
        int gap_pct;

        gap_pct = (flow == FLOW_SEND_GAPS) ? 84 : (flow == FLOW_BOTH) ? 8 : 0;
        while (roll(gap_pct)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= base_char;
        s_axis_tlast <= is_last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_base(base_char, is_last);
    endtask

    task automatic send_read();
        foreach (read_bases[i])
            send_base(read_bases[i], i == read_bases.size() - 1);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic write_min_overlap(logic [4:0] value);
        hold_until_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_min_overlap(value);
    endtask

    // Exact minimum match, a one-base read, a match after a zero byte, and lower case.
    task automatic run_directed();
        load_text("CTGTCTCT");
        send_read();
        read_bases.delete();
        read_bases.insert(0, 8'hFF);
        send_read();
        load_text("AGATGTGT");
        read_bases.push_front(8'h00);
        send_read();
        load_text("ctgtctct");
        send_read();
    endtask

    initial begin
        int  sent;
        bit  paused;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            flow = t_flow_mode'(p % 4);
            write_min_overlap(MIN_PLAN[p]);
            if (p == 0)
                run_directed();
            sent = 0;
            paused = 1'b0;
            while (sent < BASES_PER_PHASE) begin
                make_read();
                send_read();
                sent += read_bases.size();
                // Let the result side empty completely once in a while.
                if (p % 3 == 1 && !paused && sent >= BASES_PER_PHASE / 2) begin
                    hold_until_drained();
                    paused = 1'b1;
                end
            end
        end

        hold_until_drained();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bases in %0d reads across %0d minimum-overlap settings.",
            sb.bases_taken, sb.reads_done, NUM_PHASES);
        $display("%0d reads hit an adapter, %0d of them across the whole window.",
            sb.reads_matched, sb.full_window_hits);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a stuck handshake.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
